// ===== design/ktns_pkg.sv =====
// package for the knight tour next square unit
// holds item structs, sequencer states, base-tour roms and move tables
`timescale 1ns / 1ps
package ktns_pkg;

  typedef struct packed {
    logic [7:0] cur_x;
    logic [7:0] cur_y;
    logic [7:0] prev_x;
    logic [7:0] prev_y;
  } ktns_in_t;

  typedef struct packed {
    logic [7:0]  next_x;
    logic [7:0]  next_y;
    logic [15:0] next_index;
    logic        error;
  } ktns_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HALVE,
    ST_LOOKUP,
    ST_SELECT,
    ST_INDEX,
    ST_OUT
  } ktns_state_t;

  localparam int unsigned HALVE_LIMIT = 16;
  localparam logic [3:0] NO_JUNCTION = 4'd8;

  localparam logic [2:0] JUNCTION_FROM [8] = '{3'd3, 3'd7, 3'd6, 3'd2, 3'd7, 3'd3, 3'd2, 3'd6};
  localparam logic [2:0] JUNCTION_TO [8]   = '{3'd4, 3'd3, 3'd7, 3'd4, 3'd0, 3'd7, 3'd3, 3'd0};
  localparam logic signed [2:0] MOVE_DX [8] = '{-3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2};
  localparam logic signed [2:0] MOVE_DY [8] = '{-3'sd1, -3'sd2, -3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd1};

  // pack one rom square: two 3-bit move types
  function automatic logic [5:0] mv(input int a, input int b);
    return {3'(a), 3'(b)};
  endfunction

  // base-tour rom lookup; valid says a block of this size exists
  // sx is the wide side, ly row, lx column
  function automatic logic [6:0] base_rom(input logic [3:0] sx, input logic [3:0] sy,
                                          input logic [3:0] lx, input logic [3:0] ly);
    logic [5:0] r;
    logic       v;
    r = 6'd0;
    v = 1'b1;
    if (sx == 4'd6 && sy == 4'd6) begin
      unique case ({ly, lx})
        {4'd0,4'd0}: r = mv(4,5); {4'd0,4'd1}: r = mv(5,6); {4'd0,4'd2}: r = mv(4,7);
        {4'd0,4'd3}: r = mv(4,7); {4'd0,4'd4}: r = mv(5,7); {4'd0,4'd5}: r = mv(6,7);
        {4'd1,4'd0}: r = mv(3,4); {4'd1,4'd1}: r = mv(3,6); {4'd1,4'd2}: r = mv(0,3);
        {4'd1,4'd3}: r = mv(3,5); {4'd1,4'd4}: r = mv(0,6); {4'd1,4'd5}: r = mv(0,7);
        {4'd2,4'd0}: r = mv(2,5); {4'd2,4'd1}: r = mv(1,4); {4'd2,4'd2}: r = mv(0,1);
        {4'd2,4'd3}: r = mv(3,4); {4'd2,4'd4}: r = mv(2,5); {4'd2,4'd5}: r = mv(1,6);
        {4'd3,4'd0}: r = mv(2,5); {4'd3,4'd1}: r = mv(5,6); {4'd3,4'd2}: r = mv(4,7);
        {4'd3,4'd3}: r = mv(0,2); {4'd3,4'd4}: r = mv(1,5); {4'd3,4'd5}: r = mv(0,6);
        {4'd4,4'd0}: r = mv(3,4); {4'd4,4'd1}: r = mv(1,4); {4'd4,4'd2}: r = mv(4,7);
        {4'd4,4'd3}: r = mv(4,7); {4'd4,4'd4}: r = mv(0,2); {4'd4,4'd5}: r = mv(1,7);
        {4'd5,4'd0}: r = mv(2,3); {4'd5,4'd1}: r = mv(1,3); {4'd5,4'd2}: r = mv(1,0);
        {4'd5,4'd3}: r = mv(3,0); {4'd5,4'd4}: r = mv(0,2); {4'd5,4'd5}: r = mv(0,1);
        default: v = 1'b0;
      endcase
    end else if (sx == 4'd8 && sy == 4'd6) begin
      unique case ({ly, lx})
        {4'd0,4'd0}: r = mv(4,5); {4'd0,4'd1}: r = mv(4,6); {4'd0,4'd2}: r = mv(4,7);
        {4'd0,4'd3}: r = mv(4,7); {4'd0,4'd4}: r = mv(4,6); {4'd0,4'd5}: r = mv(4,6);
        {4'd0,4'd6}: r = mv(5,7); {4'd0,4'd7}: r = mv(6,7);
        {4'd1,4'd0}: r = mv(3,4); {4'd1,4'd1}: r = mv(3,6); {4'd1,4'd2}: r = mv(6,0);
        {4'd1,4'd3}: r = mv(0,4); {4'd1,4'd4}: r = mv(0,3); {4'd1,4'd5}: r = mv(0,3);
        {4'd1,4'd6}: r = mv(0,5); {4'd1,4'd7}: r = mv(0,7);
        {4'd2,4'd0}: r = mv(2,5); {4'd2,4'd1}: r = mv(1,4); {4'd2,4'd2}: r = mv(0,5);
        {4'd2,4'd3}: r = mv(2,5); {4'd2,4'd4}: r = mv(2,5); {4'd2,4'd5}: r = mv(0,3);
        {4'd2,4'd6}: r = mv(2,5); {4'd2,4'd7}: r = mv(1,6);
        {4'd3,4'd0}: r = mv(2,5); {4'd3,4'd1}: r = mv(2,6); {4'd3,4'd2}: r = mv(6,7);
        {4'd3,4'd3}: r = mv(0,6); {4'd3,4'd4}: r = mv(6,7); {4'd3,4'd5}: r = mv(5,6);
        {4'd3,4'd6}: r = mv(5,7); {4'd3,4'd7}: r = mv(1,6);
        {4'd4,4'd0}: r = mv(3,4); {4'd4,4'd1}: r = mv(1,4); {4'd4,4'd2}: r = mv(3,7);
        {4'd4,4'd3}: r = mv(1,4); {4'd4,4'd4}: r = mv(1,3); {4'd4,4'd5}: r = mv(1,4);
        {4'd4,4'd6}: r = mv(2,7); {4'd4,4'd7}: r = mv(1,7);
        {4'd5,4'd0}: r = mv(2,3); {4'd5,4'd1}: r = mv(1,2); {4'd5,4'd2}: r = mv(0,2);
        {4'd5,4'd3}: r = mv(0,2); {4'd5,4'd4}: r = mv(2,3); {4'd5,4'd5}: r = mv(0,3);
        {4'd5,4'd6}: r = mv(1,2); {4'd5,4'd7}: r = mv(0,1);
        default: v = 1'b0;
      endcase
    end else if (sx == 4'd8 && sy == 4'd8) begin
      unique case ({ly, lx})
        {4'd0,4'd0}: r = mv(4,5); {4'd0,4'd1}: r = mv(5,6); {4'd0,4'd2}: r = mv(5,7);
        {4'd0,4'd3}: r = mv(4,7); {4'd0,4'd4}: r = mv(5,7); {4'd0,4'd5}: r = mv(4,7);
        {4'd0,4'd6}: r = mv(5,7); {4'd0,4'd7}: r = mv(6,7);
        {4'd1,4'd0}: r = mv(3,5); {4'd1,4'd1}: r = mv(3,6); {4'd1,4'd2}: r = mv(0,3);
        {4'd1,4'd3}: r = mv(3,6); {4'd1,4'd4}: r = mv(3,6); {4'd1,4'd5}: r = mv(0,3);
        {4'd1,4'd6}: r = mv(5,6); {4'd1,4'd7}: r = mv(0,7);
        {4'd2,4'd0}: r = mv(2,5); {4'd2,4'd1}: r = mv(1,6); {4'd2,4'd2}: r = mv(1,7);
        {4'd2,4'd3}: r = mv(1,5); {4'd2,4'd4}: r = mv(4,5); {4'd2,4'd5}: r = mv(1,3);
        {4'd2,4'd6}: r = mv(2,5); {4'd2,4'd7}: r = mv(1,6);
        {4'd3,4'd0}: r = mv(2,3); {4'd3,4'd1}: r = mv(1,5); {4'd3,4'd2}: r = mv(2,5);
        {4'd3,4'd3}: r = mv(2,4); {4'd3,4'd4}: r = mv(6,7); {4'd3,4'd5}: r = mv(2,4);
        {4'd3,4'd6}: r = mv(0,5); {4'd3,4'd7}: r = mv(1,6);
        {4'd4,4'd0}: r = mv(2,5); {4'd4,4'd1}: r = mv(1,6); {4'd4,4'd2}: r = mv(3,7);
        {4'd4,4'd3}: r = mv(4,5); {4'd4,4'd4}: r = mv(1,6); {4'd4,4'd5}: r = mv(0,1);
        {4'd4,4'd6}: r = mv(2,5); {4'd4,4'd7}: r = mv(0,1);
        {4'd5,4'd0}: r = mv(3,5); {4'd5,4'd1}: r = mv(5,6); {4'd5,4'd2}: r = mv(1,4);
        {4'd5,4'd3}: r = mv(1,2); {4'd5,4'd4}: r = mv(4,5); {4'd5,4'd5}: r = mv(0,5);
        {4'd5,4'd6}: r = mv(2,5); {4'd5,4'd7}: r = mv(1,6);
        {4'd6,4'd0}: r = mv(2,4); {4'd6,4'd1}: r = mv(1,4); {4'd6,4'd2}: r = mv(4,7);
        {4'd6,4'd3}: r = mv(2,7); {4'd6,4'd4}: r = mv(0,1); {4'd6,4'd5}: r = mv(4,7);
        {4'd6,4'd6}: r = mv(0,7); {4'd6,4'd7}: r = mv(1,7);
        {4'd7,4'd0}: r = mv(2,3); {4'd7,4'd1}: r = mv(1,3); {4'd7,4'd2}: r = mv(0,1);
        {4'd7,4'd3}: r = mv(0,3); {4'd7,4'd4}: r = mv(0,3); {4'd7,4'd5}: r = mv(1,3);
        {4'd7,4'd6}: r = mv(1,2); {4'd7,4'd7}: r = mv(0,1);
        default: v = 1'b0;
      endcase
    end else if (sx == 4'd10 && sy == 4'd8) begin
      unique case ({ly, lx})
        {4'd0,4'd0}: r = mv(4,5); {4'd0,4'd1}: r = mv(4,6); {4'd0,4'd2}: r = mv(4,7);
        {4'd0,4'd3}: r = mv(4,7); {4'd0,4'd4}: r = mv(4,7); {4'd0,4'd5}: r = mv(6,7);
        {4'd0,4'd6}: r = mv(4,7); {4'd0,4'd7}: r = mv(4,7); {4'd0,4'd8}: r = mv(5,7);
        {4'd0,4'd9}: r = mv(6,7);
        {4'd1,4'd0}: r = mv(3,4); {4'd1,4'd1}: r = mv(3,6); {4'd1,4'd2}: r = mv(0,3);
        {4'd1,4'd3}: r = mv(0,3); {4'd1,4'd4}: r = mv(0,3); {4'd1,4'd5}: r = mv(0,3);
        {4'd1,4'd6}: r = mv(0,3); {4'd1,4'd7}: r = mv(3,4); {4'd1,4'd8}: r = mv(0,5);
        {4'd1,4'd9}: r = mv(0,6);
        {4'd2,4'd0}: r = mv(2,4); {4'd2,4'd1}: r = mv(1,6); {4'd2,4'd2}: r = mv(0,6);
        {4'd2,4'd3}: r = mv(6,7); {4'd2,4'd4}: r = mv(2,4); {4'd2,4'd5}: r = mv(4,6);
        {4'd2,4'd6}: r = mv(5,7); {4'd2,4'd7}: r = mv(5,6); {4'd2,4'd8}: r = mv(2,5);
        {4'd2,4'd9}: r = mv(0,1);
        {4'd3,4'd0}: r = mv(2,5); {4'd3,4'd1}: r = mv(3,5); {4'd3,4'd2}: r = mv(0,5);
        {4'd3,4'd3}: r = mv(4,6); {4'd3,4'd4}: r = mv(3,5); {4'd3,4'd5}: r = mv(5,7);
        {4'd3,4'd6}: r = mv(0,4); {4'd3,4'd7}: r = mv(0,7); {4'd3,4'd8}: r = mv(2,5);
        {4'd3,4'd9}: r = mv(1,7);
        {4'd4,4'd0}: r = mv(2,5); {4'd4,4'd1}: r = mv(2,6); {4'd4,4'd2}: r = mv(2,7);
        {4'd4,4'd3}: r = mv(3,5); {4'd4,4'd4}: r = mv(2,4); {4'd4,4'd5}: r = mv(0,3);
        {4'd4,4'd6}: r = mv(2,7); {4'd4,4'd7}: r = mv(1,3); {4'd4,4'd8}: r = mv(0,1);
        {4'd4,4'd9}: r = mv(1,6);
        {4'd5,4'd0}: r = mv(3,5); {4'd5,4'd1}: r = mv(1,6); {4'd5,4'd2}: r = mv(1,2);
        {4'd5,4'd3}: r = mv(1,6); {4'd5,4'd4}: r = mv(3,5); {4'd5,4'd5}: r = mv(1,7);
        {4'd5,4'd6}: r = mv(0,1); {4'd5,4'd7}: r = mv(4,5); {4'd5,4'd8}: r = mv(5,7);
        {4'd5,4'd9}: r = mv(1,6);
        {4'd6,4'd0}: r = mv(2,4); {4'd6,4'd1}: r = mv(1,4); {4'd6,4'd2}: r = mv(4,7);
        {4'd6,4'd3}: r = mv(3,7); {4'd6,4'd4}: r = mv(1,4); {4'd6,4'd5}: r = mv(4,7);
        {4'd6,4'd6}: r = mv(3,7); {4'd6,4'd7}: r = mv(4,7); {4'd6,4'd8}: r = mv(2,7);
        {4'd6,4'd9}: r = mv(0,7);
        {4'd7,4'd0}: r = mv(2,3); {4'd7,4'd1}: r = mv(1,3); {4'd7,4'd2}: r = mv(0,2);
        {4'd7,4'd3}: r = mv(0,3); {4'd7,4'd4}: r = mv(0,3); {4'd7,4'd5}: r = mv(1,3);
        {4'd7,4'd6}: r = mv(0,3); {4'd7,4'd7}: r = mv(0,3); {4'd7,4'd8}: r = mv(1,2);
        {4'd7,4'd9}: r = mv(0,1);
        default: v = 1'b0;
      endcase
    end else if (sx == 4'd10 && sy == 4'd10) begin
      unique case ({ly, lx})
        {4'd0,4'd0}: r = mv(4,5); {4'd0,4'd1}: r = mv(4,6); {4'd0,4'd2}: r = mv(5,7);
        {4'd0,4'd3}: r = mv(4,6); {4'd0,4'd4}: r = mv(4,7); {4'd0,4'd5}: r = mv(6,7);
        {4'd0,4'd6}: r = mv(5,7); {4'd0,4'd7}: r = mv(4,7); {4'd0,4'd8}: r = mv(5,7);
        {4'd0,4'd9}: r = mv(6,7);
        {4'd1,4'd0}: r = mv(3,4); {4'd1,4'd1}: r = mv(4,6); {4'd1,4'd2}: r = mv(0,3);
        {4'd1,4'd3}: r = mv(0,3); {4'd1,4'd4}: r = mv(3,5); {4'd1,4'd5}: r = mv(0,3);
        {4'd1,4'd6}: r = mv(0,3); {4'd1,4'd7}: r = mv(3,4); {4'd1,4'd8}: r = mv(5,6);
        {4'd1,4'd9}: r = mv(6,0);
        {4'd2,4'd0}: r = mv(2,4); {4'd2,4'd1}: r = mv(1,6); {4'd2,4'd2}: r = mv(0,2);
        {4'd2,4'd3}: r = mv(0,1); {4'd2,4'd4}: r = mv(2,4); {4'd2,4'd5}: r = mv(6,7);
        {4'd2,4'd6}: r = mv(5,6); {4'd2,4'd7}: r = mv(1,6); {4'd2,4'd8}: r = mv(2,5);
        {4'd2,4'd9}: r = mv(0,1);
        {4'd3,4'd0}: r = mv(2,4); {4'd3,4'd1}: r = mv(5,6); {4'd3,4'd2}: r = mv(0,6);
        {4'd3,4'd3}: r = mv(3,5); {4'd3,4'd4}: r = mv(4,5); {4'd3,4'd5}: r = mv(1,4);
        {4'd3,4'd6}: r = mv(0,4); {4'd3,4'd7}: r = mv(2,6); {4'd3,4'd8}: r = mv(2,5);
        {4'd3,4'd9}: r = mv(1,6);
        {4'd4,4'd0}: r = mv(2,5); {4'd4,4'd1}: r = mv(4,5); {4'd4,4'd2}: r = mv(0,7);
        {4'd4,4'd3}: r = mv(4,5); {4'd4,4'd4}: r = mv(2,6); {4'd4,4'd5}: r = mv(2,5);
        {4'd4,4'd6}: r = mv(0,2); {4'd4,4'd7}: r = mv(0,1); {4'd4,4'd8}: r = mv(0,6);
        {4'd4,4'd9}: r = mv(1,6);
        {4'd5,4'd0}: r = mv(2,3); {4'd5,4'd1}: r = mv(2,6); {4'd5,4'd2}: r = mv(1,7);
        {4'd5,4'd3}: r = mv(0,5); {4'd5,4'd4}: r = mv(1,7); {4'd5,4'd5}: r = mv(0,1);
        {4'd5,4'd6}: r = mv(2,6); {4'd5,4'd7}: r = mv(6,7); {4'd5,4'd8}: r = mv(2,6);
        {4'd5,4'd9}: r = mv(1,7);
        {4'd6,4'd0}: r = mv(3,5); {4'd6,4'd1}: r = mv(1,6); {4'd6,4'd2}: r = mv(1,3);
        {4'd6,4'd3}: r = mv(2,7); {4'd6,4'd4}: r = mv(1,5); {4'd6,4'd5}: r = mv(3,7);
        {4'd6,4'd6}: r = mv(1,7); {4'd6,4'd7}: r = mv(2,3); {4'd6,4'd8}: r = mv(2,5);
        {4'd6,4'd9}: r = mv(6,7);
        {4'd7,4'd0}: r = mv(2,5); {4'd7,4'd1}: r = mv(3,6); {4'd7,4'd2}: r = mv(5,6);
        {4'd7,4'd3}: r = mv(3,7); {4'd7,4'd4}: r = mv(1,3); {4'd7,4'd5}: r = mv(2,7);
        {4'd7,4'd6}: r = mv(2,6); {4'd7,4'd7}: r = mv(2,3); {4'd7,4'd8}: r = mv(5,6);
        {4'd7,4'd9}: r = mv(6,7);
        {4'd8,4'd0}: r = mv(2,4); {4'd8,4'd1}: r = mv(1,3); {4'd8,4'd2}: r = mv(4,7);
        {4'd8,4'd3}: r = mv(3,4); {4'd8,4'd4}: r = mv(4,7); {4'd8,4'd5}: r = mv(1,7);
        {4'd8,4'd6}: r = mv(4,7); {4'd8,4'd7}: r = mv(3,4); {4'd8,4'd8}: r = mv(2,7);
        {4'd8,4'd9}: r = mv(1,7);
        {4'd9,4'd0}: r = mv(2,3); {4'd9,4'd1}: r = mv(1,2); {4'd9,4'd2}: r = mv(0,3);
        {4'd9,4'd3}: r = mv(1,3); {4'd9,4'd4}: r = mv(0,3); {4'd9,4'd5}: r = mv(0,2);
        {4'd9,4'd6}: r = mv(0,3); {4'd9,4'd7}: r = mv(2,3); {4'd9,4'd8}: r = mv(0,2);
        {4'd9,4'd9}: r = mv(0,1);
        default: v = 1'b0;
      endcase
    end else if (sx == 4'd12 && sy == 4'd10) begin
      unique case ({ly, lx})
        {4'd0,4'd0}: r = mv(4,5); {4'd0,4'd1}: r = mv(4,6); {4'd0,4'd2}: r = mv(6,7);
        {4'd0,4'd3}: r = mv(4,7); {4'd0,4'd4}: r = mv(5,6); {4'd0,4'd5}: r = mv(4,7);
        {4'd0,4'd6}: r = mv(5,7); {4'd0,4'd7}: r = mv(4,7); {4'd0,4'd8}: r = mv(4,6);
        {4'd0,4'd9}: r = mv(4,7); {4'd0,4'd10}: r = mv(5,6); {4'd0,4'd11}: r = mv(6,7);
        {4'd1,4'd0}: r = mv(3,5); {4'd1,4'd1}: r = mv(3,6); {4'd1,4'd2}: r = mv(0,7);
        {4'd1,4'd3}: r = mv(0,3); {4'd1,4'd4}: r = mv(3,6); {4'd1,4'd5}: r = mv(0,3);
        {4'd1,4'd6}: r = mv(6,7); {4'd1,4'd7}: r = mv(0,3); {4'd1,4'd8}: r = mv(5,6);
        {4'd1,4'd9}: r = mv(0,3); {4'd1,4'd10}: r = mv(0,5); {4'd1,4'd11}: r = mv(0,6);
        {4'd2,4'd0}: r = mv(2,3); {4'd2,4'd1}: r = mv(1,2); {4'd2,4'd2}: r = mv(6,7);
        {4'd2,4'd3}: r = mv(2,6); {4'd2,4'd4}: r = mv(3,4); {4'd2,4'd5}: r = mv(1,7);
        {4'd2,4'd6}: r = mv(5,6); {4'd2,4'd7}: r = mv(1,2); {4'd2,4'd8}: r = mv(5,7);
        {4'd2,4'd9}: r = mv(2,4); {4'd2,4'd10}: r = mv(2,5); {4'd2,4'd11}: r = mv(1,6);
        {4'd3,4'd0}: r = mv(2,3); {4'd3,4'd1}: r = mv(1,6); {4'd3,4'd2}: r = mv(4,5);
        {4'd3,4'd3}: r = mv(2,3); {4'd3,4'd4}: r = mv(4,7); {4'd3,4'd5}: r = mv(2,7);
        {4'd3,4'd6}: r = mv(0,3); {4'd3,4'd7}: r = mv(2,7); {4'd3,4'd8}: r = mv(5,7);
        {4'd3,4'd9}: r = mv(1,6); {4'd3,4'd10}: r = mv(2,5); {4'd3,4'd11}: r = mv(0,1);
        {4'd4,4'd0}: r = mv(4,5); {4'd4,4'd1}: r = mv(2,6); {4'd4,4'd2}: r = mv(2,3);
        {4'd4,4'd3}: r = mv(3,5); {4'd4,4'd4}: r = mv(0,4); {4'd4,4'd5}: r = mv(2,3);
        {4'd4,4'd6}: r = mv(0,3); {4'd4,4'd7}: r = mv(1,7); {4'd4,4'd8}: r = mv(4,6);
        {4'd4,4'd9}: r = mv(1,7); {4'd4,4'd10}: r = mv(2,5); {4'd4,4'd11}: r = mv(1,6);
        {4'd5,4'd0}: r = mv(2,4); {4'd5,4'd1}: r = mv(4,5); {4'd5,4'd2}: r = mv(0,7);
        {4'd5,4'd3}: r = mv(1,6); {4'd5,4'd4}: r = mv(4,6); {4'd5,4'd5}: r = mv(3,6);
        {4'd5,4'd6}: r = mv(0,7); {4'd5,4'd7}: r = mv(3,6); {4'd5,4'd8}: r = mv(2,5);
        {4'd5,4'd9}: r = mv(1,6); {4'd5,4'd10}: r = mv(0,7); {4'd5,4'd11}: r = mv(1,6);
        {4'd6,4'd0}: r = mv(2,3); {4'd6,4'd1}: r = mv(1,6); {4'd6,4'd2}: r = mv(0,7);
        {4'd6,4'd3}: r = mv(0,5); {4'd6,4'd4}: r = mv(1,3); {4'd6,4'd5}: r = mv(4,6);
        {4'd6,4'd6}: r = mv(0,7); {4'd6,4'd7}: r = mv(2,4); {4'd6,4'd8}: r = mv(3,7);
        {4'd6,4'd9}: r = mv(4,5); {4'd6,4'd10}: r = mv(2,5); {4'd6,4'd11}: r = mv(1,6);
        {4'd7,4'd0}: r = mv(3,5); {4'd7,4'd1}: r = mv(5,6); {4'd7,4'd2}: r = mv(1,2);
        {4'd7,4'd3}: r = mv(2,7); {4'd7,4'd4}: r = mv(2,3); {4'd7,4'd5}: r = mv(5,6);
        {4'd7,4'd6}: r = mv(2,3); {4'd7,4'd7}: r = mv(0,5); {4'd7,4'd8}: r = mv(2,7);
        {4'd7,4'd9}: r = mv(0,1); {4'd7,4'd10}: r = mv(2,5); {4'd7,4'd11}: r = mv(0,6);
        {4'd8,4'd0}: r = mv(2,4); {4'd8,4'd1}: r = mv(3,4); {4'd8,4'd2}: r = mv(4,7);
        {4'd8,4'd3}: r = mv(4,7); {4'd8,4'd4}: r = mv(1,2); {4'd8,4'd5}: r = mv(4,7);
        {4'd8,4'd6}: r = mv(3,4); {4'd8,4'd7}: r = mv(4,7); {4'd8,4'd8}: r = mv(4,7);
        {4'd8,4'd9}: r = mv(4,7); {4'd8,4'd10}: r = mv(1,2); {4'd8,4'd11}: r = mv(1,7);
        {4'd9,4'd0}: r = mv(2,3); {4'd9,4'd1}: r = mv(1,3); {4'd9,4'd2}: r = mv(0,1);
        {4'd9,4'd3}: r = mv(0,3); {4'd9,4'd4}: r = mv(0,2); {4'd9,4'd5}: r = mv(0,3);
        {4'd9,4'd6}: r = mv(1,3); {4'd9,4'd7}: r = mv(0,3); {4'd9,4'd8}: r = mv(0,1);
        {4'd9,4'd9}: r = mv(0,3); {4'd9,4'd10}: r = mv(0,2); {4'd9,4'd11}: r = mv(0,1);
        default: v = 1'b0;
      endcase
    end else begin
      v = 1'b0;
    end
    return {v, r};
  endfunction

endpackage

// ===== design/ktns_halver.sv =====
// one halving step of both block axes plus junction marking
// depends on ktns_pkg
`timescale 1ns / 1ps
module ktns_halver
  import ktns_pkg::*;
#(
  parameter int unsigned SW = 10
) (
  input  logic [SW-1:0] sx,
  input  logic [SW-1:0] sy,
  input  logic [SW-1:0] lx,
  input  logic [SW-1:0] ly,
  input  logic [3:0]    attr,
  output logic [SW-1:0] sx_next,
  output logic [SW-1:0] sy_next,
  output logic [SW-1:0] lx_next,
  output logic [SW-1:0] ly_next,
  output logic [3:0]    attr_next,
  output logic          done
);

  logic [SW-1:0] hx, hy, leftx, rightx, lefty, righty;
  logic          hix, hiy;

  always_comb begin
    hx = sx >> 1;
    hy = sy >> 1;
    leftx  = hx - SW'(hx[0]);
    rightx = hx + SW'(hx[0]);
    lefty  = hy - SW'(hy[0]);
    righty = hy + SW'(hy[0]);
    hix = (lx >= leftx);
    hiy = (ly >= lefty);
    sx_next = hix ? rightx : leftx;
    sy_next = hiy ? righty : lefty;
    lx_next = hix ? lx - leftx : lx;
    ly_next = hiy ? ly - lefty : ly;

    attr_next = attr;
    priority if (!hix && !hiy && lx_next == sx_next - SW'(3) && ly_next == sy_next - SW'(1))
      attr_next = 4'd0;
    else if (!hix && !hiy && lx_next == sx_next - SW'(1) && ly_next == sy_next - SW'(2))
      attr_next = 4'd1;
    else if (hix && !hiy && lx_next == SW'(1) && ly_next == sy_next - SW'(3))
      attr_next = 4'd2;
    else if (hix && !hiy && lx_next == '0 && ly_next == sy_next - SW'(1))
      attr_next = 4'd3;
    else if (hix && hiy && lx_next == SW'(2) && ly_next == '0)
      attr_next = 4'd4;
    else if (hix && hiy && lx_next == '0 && ly_next == SW'(1))
      attr_next = 4'd5;
    else if (!hix && hiy && lx_next == sx_next - SW'(2) && ly_next == SW'(2))
      attr_next = 4'd6;
    else if (!hix && hiy && lx_next == sx_next - SW'(1) && ly_next == '0)
      attr_next = 4'd7;

    done = sx_next <= SW'(12) && sy_next <= SW'(12) && (sx_next < SW'(12) || sy_next < SW'(12));
  end

endmodule

// ===== design/knight_tour_next_square_unit.sv =====
// knight tour next square unit: top level with sequencer and output register
// result valid in ST_OUT after ST_HALVE, ST_LOOKUP, ST_SELECT and ST_INDEX; for boards
// of 12 or more ST_HALVE repeats per halving level (about log2(board/6), up to 16 levels)
// a new item is taken only after the result leaves
// the halving step is one shared unit reused each cycle
// synchronous active-high reset: board size returns to 8, sequencer idle
`timescale 1ns / 1ps
module knight_tour_next_square_unit
  import ktns_pkg::*;
#(
  parameter int unsigned MAX_BOARD = 256
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  ktns_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ktns_out_t out_data
);

  localparam int unsigned SW = 10;

  ktns_state_t state, state_next;
  logic [8:0]  board_size;
  ktns_in_t    item;
  logic [SW-1:0] sx, sy, lx, ly;
  logic [3:0]  attr;
  logic [4:0]  iter;
  logic        err;
  logic [2:0]  ta, tb;
  logic [7:0]  nx, ny;
  logic [15:0] idx;

  logic [SW-1:0] h_sx, h_sy, h_lx, h_ly;
  logic [3:0]    h_attr;
  logic          h_done;

  ktns_halver #(.SW(SW)) u_halver (
    .sx(sx), .sy(sy), .lx(lx), .ly(ly), .attr(attr),
    .sx_next(h_sx), .sy_next(h_sy), .lx_next(h_lx), .ly_next(h_ly),
    .attr_next(h_attr), .done(h_done)
  );

  // lookup with transpose
  logic          swp;
  logic [3:0]    bsx, bsy, blx, bly;
  logic [6:0]    rom;
  logic [2:0]    ra, rb, fa, fb, jf, jt;
  logic          jerr;
  always_comb begin
    swp = sx < sy;
    bsx = swp ? sy[3:0] : sx[3:0];
    bsy = swp ? sx[3:0] : sy[3:0];
    blx = swp ? ly[3:0] : lx[3:0];
    bly = swp ? lx[3:0] : ly[3:0];
    rom = base_rom(bsx, bsy, blx, bly);
    if ((swp ? sy : sx) > SW'(12) || (swp ? sx : sy) > SW'(12)) rom[6] = 1'b0;
    ra = rom[5:3];
    rb = rom[2:0];
    if (swp) begin
      ra = 3'd1 - ra;
      rb = 3'd1 - rb;
    end
    jf = JUNCTION_FROM[attr[2:0]];
    jt = JUNCTION_TO[attr[2:0]];
    fa = ra;
    fb = rb;
    jerr = 1'b0;
    if (attr != NO_JUNCTION) begin
      if (ra == jf) fa = jt;
      else if (rb == jf) fb = jt;
      else jerr = 1'b1;
    end
  end

  // candidate squares, signed 10-bit
  logic signed [9:0] ax, ay, bx2, by2, px, py, sx2, sy2;
  logic              hit_a, hit_b, off;
  always_comb begin
    ax  = $signed({2'b00, item.cur_x}) + 10'(MOVE_DX[ta]);
    ay  = $signed({2'b00, item.cur_y}) + 10'(MOVE_DY[ta]);
    bx2 = $signed({2'b00, item.cur_x}) + 10'(MOVE_DX[tb]);
    by2 = $signed({2'b00, item.cur_y}) + 10'(MOVE_DY[tb]);
    px  = $signed({2'b00, item.prev_x});
    py  = $signed({2'b00, item.prev_y});
    hit_a = ax == px && ay == py;
    hit_b = bx2 == px && by2 == py;
    sx2 = hit_a ? bx2 : ax;
    sy2 = hit_a ? by2 : ay;
    off = sx2 < 0 || sy2 < 0 || sx2 >= $signed({1'b0, board_size})
          || sy2 >= $signed({1'b0, board_size});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_HALVE;
      ST_HALVE:  if (err || board_size < 9'd12 || h_done || iter == 5'(HALVE_LIMIT - 1))
                   state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_SELECT;
      ST_SELECT: state_next = ST_INDEX;
      ST_INDEX:  state_next = ST_OUT;
      ST_OUT:    if (!out_stall) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != ST_IDLE;
    out_valid = state == ST_OUT;
    out_data.next_x     = err ? 8'd0 : nx;
    out_data.next_y     = err ? 8'd0 : ny;
    out_data.next_index = err ? 16'd0 : idx;
    out_data.error      = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      board_size <= 9'd8;
    end else begin
      state <= state_next;
      if (cfg_we) board_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        item <= in_data;
        sx <= SW'(board_size);
        sy <= SW'(board_size);
        lx <= SW'(in_data.cur_x);
        ly <= SW'(in_data.cur_y);
        attr <= NO_JUNCTION;
        iter <= '0;
        err <= 32'(board_size) > MAX_BOARD || {1'b0, in_data.cur_x} >= board_size
               || {1'b0, in_data.cur_y} >= board_size;
      end
      ST_HALVE: begin
        if (!err && board_size >= 9'd12) begin
          sx <= h_sx; sy <= h_sy; lx <= h_lx; ly <= h_ly; attr <= h_attr;
          iter <= iter + 5'd1;
          if (!h_done && iter == 5'(HALVE_LIMIT - 1)) err <= 1'b1;
        end
      end
      ST_LOOKUP: begin
        ta <= fa;
        tb <= fb;
        if (!rom[6] || jerr) err <= 1'b1;
      end
      ST_SELECT: begin
        nx <= sx2[7:0];
        ny <= sy2[7:0];
        if ((!hit_a && !hit_b) || off) err <= 1'b1;
      end
      ST_INDEX: idx <= 16'(nx) * 16'(board_size) + 16'(ny);
      ST_OUT: ;
      default: ;
    endcase
  end

endmodule
